@@ design/hall_throttle_conditioner_assert.svh @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner assertion macros
// Shared property macros for the conditioner's internal checks.
// ----------------------------------------------------------------------------
`ifndef HALL_THROTTLE_CONDITIONER_ASSERT_SVH
`define HALL_THROTTLE_CONDITIONER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htc check failed");

// antecedent implies consequent in the next cycle
`define HTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htc check failed");

`endif

@@ design/htc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner package
// Payload types, configuration bundle and constants shared by all modules.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int SMP_W   = 12;
  localparam int THR_W   = 10;
  localparam int DIV_NW  = 26;
  localparam int DIV_DW  = 14;
  localparam int WIN_CAP = 128;

  localparam logic [13:0] K_PCT    = 14'd100;
  localparam logic [13:0] K_PCT2   = 14'd10000;
  localparam logic [8:0]  K_SMOOTH = 9'd300;

  // reciprocals for exact floor division by 100 and 10000 over the operand ranges in use
  localparam logic [17:0] K_RCP100  = 18'd167773;
  localparam int          RCP100_SH = 24;
  localparam logic [20:0] K_RCP10K  = 21'd1717987;
  localparam int          RCP10K_SH = 34;

  typedef struct packed {
    logic             operation;
    logic [SMP_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [SMP_W-1:0] filtered;
    logic [THR_W-1:0] throttle;
  } out_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_SQUARE = 2'd1,
    CURVE_SQRT   = 2'd2,
    CURVE_SMOOTH = 2'd3
  } curve_t;

  typedef enum logic [2:0] {
    REG_ADC_MIN  = 3'd0,
    REG_ADC_MAX  = 3'd1,
    REG_DZ_LOW   = 3'd2,
    REG_DZ_HIGH  = 3'd3,
    REG_THR_MIN  = 3'd4,
    REG_THR_MAX  = 3'd5,
    REG_CURVE    = 3'd6,
    REG_REVERSE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] adc_min;
    logic [11:0] adc_max;
    logic [9:0]  dz_low;
    logic [9:0]  dz_high;
    logic [9:0]  thr_min;
    logic [9:0]  thr_max;
    curve_t      curve;
    logic        reverse;
  } cfg_t;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  function automatic int win_log(input int size);
    int s;
    int lo;
    int lg;
    int up;
    s = size;
    if (s < 1) s = 1;
    if (s > WIN_CAP) s = WIN_CAP;
    lo = 1;
    lg = 0;
    while (lo * 2 <= s) begin
      lo = lo * 2;
      lg = lg + 1;
    end
    up = lo * 2;
    if (up > WIN_CAP) up = WIN_CAP;
    if ((s - lo) < (up - s)) return lg;
    if (up == lo * 2) return lg + 1;
    return lg;
  endfunction

endpackage

@@ design/htc_fifo.sv @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner queue
// Two-entry queue of window averages between the front and back ends.
// ----------------------------------------------------------------------------
`include "hall_throttle_conditioner_assert.svh"

module htc_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [htc_pkg::SMP_W-1:0] wdata,
  input  logic                     pop,
  output logic [htc_pkg::SMP_W-1:0] rdata,
  output logic                     full,
  output logic                     empty
);

  logic [htc_pkg::SMP_W-1:0] mem_r [2];
  logic                      wp_r;
  logic                      rp_r;
  logic [1:0]                cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  `HTC_ASSERT_SAME(a_no_overflow, push, !full)
  `HTC_ASSERT_SAME(a_no_underflow, pop, !empty)

endmodule

@@ design/htc_div.sv @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  htc_pkg::div_req_t req,
  output htc_pkg::div_rsp_t rsp
);

  localparam int NW = htc_pkg::DIV_NW;
  localparam int DW = htc_pkg::DIV_DW;

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(NW - 1);
        rem_r  <= '0;
        quo_r  <= req.num;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ design/htc_front.sv @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner front end
// Accepts transactions, keeps the sample window and running sum, and queues
// each window average.
// ----------------------------------------------------------------------------
module htc_front #(
  parameter int WIN_LOG  = 4,
  parameter int SAMPLE_W = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  htc_pkg::in_t              in_data,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [htc_pkg::SMP_W-1:0] q_data
);

  localparam int DEPTH  = 1 << WIN_LOG;
  localparam int SLOT_W = (WIN_LOG > 0) ? WIN_LOG : 1;
  localparam int TW     = SAMPLE_W + WIN_LOG;

  typedef enum logic {F_IDLE, F_UPD} fst_t;

  fst_t                st_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  logic [TW-1:0]       total_r;
  logic [TW-1:0]       total_nxt;
  logic [DEPTH-1:0]    vld_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0] old;
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic                acc;

  assign in_stall  = (st_r != F_IDLE) || q_full;
  assign acc       = in_valid && !in_stall;
  assign slot_nxt  = (slot_r == SLOT_W'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign old       = vld_r[slot_r] ? rd_r : '0;
  assign total_nxt = total_r - TW'(old) + TW'(smp_r);
  assign q_push    = (st_r == F_UPD);
  assign q_data    = htc_pkg::SMP_W'(total_nxt >> WIN_LOG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      slot_r  <= '0;
      total_r <= '0;
      vld_r   <= '0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (acc) begin
            if (in_data.operation) begin
              slot_r  <= '0;
              total_r <= '0;
              vld_r   <= '0;
            end else begin
              smp_r <= in_data.sample[SAMPLE_W-1:0];
              st_r  <= F_UPD;
            end
          end
        end
        F_UPD: begin
          total_r       <= total_nxt;
          vld_r[slot_r] <= 1'b1;
          slot_r        <= slot_nxt;
          st_r          <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_data.operation) rd_r <= mem[slot_r];
    if (st_r == F_UPD) mem[slot_r] <= smp_r;
  end

endmodule

@@ design/htc_back.sv @@
// ----------------------------------------------------------------------------
// Hall throttle conditioner back end
// Mirrors, band-checks and maps each queued average to a throttle value and
// holds the result for the output channel.
// ----------------------------------------------------------------------------
`include "hall_throttle_conditioner_assert.svh"

module htc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  htc_pkg::cfg_t             cfg,
  input  logic                      q_empty,
  input  logic [htc_pkg::SMP_W-1:0] q_data,
  output logic                      q_pop,
  output htc_pkg::div_req_t         div_req,
  input  htc_pkg::div_rsp_t         div_rsp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output htc_pkg::out_t             out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_REV, S_BAND, S_DIV, S_M1, S_M2, S_FRAC, S_SQRT, S_SCALE, S_PCT, S_FIN, S_OUT
  } bst_t;

  bst_t          st_r;
  logic [11:0]   v_r;
  logic [11:0]   x_r;
  logic [6:0]    n_r;
  logic [13:0]   nn_r;
  logic [8:0]    t_r;
  logic [25:0]   num_r;
  logic [13:0]   den_r;
  logic          go_r;
  logic [6:0]    f_r;
  logic [9:0]    q_r;
  logic [9:0]    res_r;
  logic [13:0]   sq_rem_r;
  logic [13:0]   sq_root_r;
  logic [13:0]   sq_bit_r;
  logic          out_valid_r;
  htc_pkg::out_t out_data_r;

  logic               desc;
  logic [9:0]         dabs;
  logic [11:0]        x_rev;
  logic signed [13:0] xs, lo_a, lo_b, hi_a, hi_b;
  logic [11:0]        hi12;
  logic               in_lo, in_hi, below, above;
  logic [11:0]        off, span;
  logic [13:0]        mul_k;
  logic [25:0]        p_band;
  logic [34:0]        p100;
  logic [42:0]        p10k;
  logic [6:0]         q10k_sat;
  logic [13:0]        sq_sum;
  logic               sq_ge;
  logic [13:0]        sq_root_nx;
  logic [13:0]        sq_rem_nx;
  logic [9:0]         lim_lo, lim_hi;

  assign desc = cfg.thr_max < cfg.thr_min;
  assign dabs = desc ? cfg.thr_min - cfg.thr_max : cfg.thr_max - cfg.thr_min;

  always_comb begin
    if (v_r <= cfg.adc_min) x_rev = cfg.adc_max;
    else if (v_r >= cfg.adc_max) x_rev = cfg.adc_min;
    else x_rev = cfg.adc_max - v_r + cfg.adc_min;
  end

  assign xs    = $signed({2'b00, x_r});
  assign lo_a  = $signed({2'b00, cfg.adc_min}) - $signed({4'b0000, cfg.dz_low});
  assign lo_b  = $signed({2'b00, cfg.adc_min}) + $signed({4'b0000, cfg.dz_low});
  assign hi_a  = $signed({2'b00, cfg.adc_max}) - $signed({4'b0000, cfg.dz_high});
  assign hi_b  = $signed({2'b00, cfg.adc_max}) + $signed({4'b0000, cfg.dz_high});
  assign hi12  = hi_a[13] ? 12'd0 : hi_a[11:0];
  assign in_lo = (xs >= lo_a) && (xs <= lo_b);
  assign in_hi = (xs >= hi_a) && (xs <= hi_b);
  assign below = (xs <= lo_b);
  assign above = (x_r >= hi12);
  assign off   = x_r - lo_b[11:0];
  assign span  = hi12 - lo_b[11:0];

  always_comb begin
    unique case (cfg.curve)
      htc_pkg::CURVE_LINEAR: mul_k = {4'b0000, dabs};
      htc_pkg::CURVE_SQRT:   mul_k = htc_pkg::K_PCT2;
      htc_pkg::CURVE_SQUARE,
      htc_pkg::CURVE_SMOOTH: mul_k = htc_pkg::K_PCT;
    endcase
  end

  assign p_band = 26'(off) * 26'(mul_k);

  // floor(num / 100) for num below 2^17, floor(num / 10000) for num below 2^22
  assign p100     = 35'(num_r[16:0]) * 35'(htc_pkg::K_RCP100);
  assign p10k     = 43'(num_r[21:0]) * 43'(htc_pkg::K_RCP10K);
  assign q10k_sat = (p10k[htc_pkg::RCP10K_SH +: 9] > 9'(htc_pkg::K_PCT)) ?
                    7'(htc_pkg::K_PCT) : p10k[htc_pkg::RCP10K_SH +: 7];

  assign sq_sum     = sq_root_r + sq_bit_r;
  assign sq_ge      = (sq_rem_r >= sq_sum);
  assign sq_root_nx = sq_ge ? (sq_root_r >> 1) + sq_bit_r : sq_root_r >> 1;
  assign sq_rem_nx  = sq_ge ? sq_rem_r - sq_sum : sq_rem_r;

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && !out_stall && (st_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            v_r  <= q_data;
            st_r <= S_REV;
          end
        end
        S_REV: begin
          x_r  <= cfg.reverse ? x_rev : v_r;
          st_r <= S_BAND;
        end
        S_BAND: begin
          if (in_lo || (!in_hi && below)) begin
            res_r <= cfg.thr_min;
            st_r  <= S_OUT;
          end else if (in_hi || above) begin
            res_r <= cfg.thr_max;
            st_r  <= S_OUT;
          end else begin
            num_r <= p_band;
            den_r <= {2'b00, span};
            go_r  <= 1'b1;
            st_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            unique case (cfg.curve)
              htc_pkg::CURVE_LINEAR: begin
                q_r  <= div_rsp.quo[9:0];
                st_r <= S_FIN;
              end
              htc_pkg::CURVE_SQUARE: begin
                num_r <= 26'(14'(div_rsp.quo[6:0]) * 14'(div_rsp.quo[6:0]));
                st_r  <= S_FRAC;
              end
              htc_pkg::CURVE_SQRT: begin
                sq_rem_r  <= div_rsp.quo[13:0];
                sq_root_r <= '0;
                sq_bit_r  <= 14'd4096;
                st_r      <= S_SQRT;
              end
              htc_pkg::CURVE_SMOOTH: begin
                n_r  <= div_rsp.quo[6:0];
                st_r <= S_M1;
              end
            endcase
          end
        end
        S_M1: begin
          nn_r <= 14'(n_r) * 14'(n_r);
          t_r  <= htc_pkg::K_SMOOTH - {1'b0, n_r, 1'b0};
          st_r <= S_M2;
        end
        S_M2: begin
          num_r <= 26'(nn_r) * 26'(t_r);
          st_r  <= S_FRAC;
        end
        S_FRAC: begin
          f_r  <= (cfg.curve == htc_pkg::CURVE_SMOOTH) ? q10k_sat
                                                       : p100[htc_pkg::RCP100_SH +: 7];
          st_r <= S_SCALE;
        end
        S_SQRT: begin
          sq_rem_r  <= sq_rem_nx;
          sq_root_r <= sq_root_nx;
          sq_bit_r  <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            f_r  <= sq_root_nx[6:0];
            st_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          num_r <= 26'(f_r) * 26'(dabs);
          st_r  <= S_PCT;
        end
        S_PCT: begin
          q_r  <= p100[htc_pkg::RCP100_SH +: 10];
          st_r <= S_FIN;
        end
        S_FIN: begin
          res_r <= desc ? cfg.thr_min - q_r : cfg.thr_min + q_r;
          st_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_data_r.filtered <= v_r;
            out_data_r.throttle <= res_r;
            st_r                <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign div_req.go  = go_r;
  assign div_req.num = num_r;
  assign div_req.den = den_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign lim_lo = desc ? cfg.thr_max : cfg.thr_min;
  assign lim_hi = desc ? cfg.thr_min : cfg.thr_max;

  `HTC_ASSERT_SAME(a_div_done_owned, div_rsp.done, st_r == S_DIV)
  `HTC_ASSERT_SAME(a_result_in_limits, st_r == S_OUT, (res_r >= lim_lo) && (res_r <= lim_hi))

endmodule

@@ design/hall_throttle_conditioner.sv @@
// Hall throttle conditioner: each sample transaction updates a sliding
// window (WIN_LENGTH rounded to a power of two) and yields one result with
// the window average and the mapped throttle; a clear transaction empties
// the window and yields nothing. The front end takes no new sample while
// it writes the last average into a two-entry queue or while that queue is
// full; the back end sets the rate. A reading in a dead band or past the
// span ends goes from the band check straight to the output; the linear,
// square, smoothstep and square root curves take longer, in that order.
// The division by the span runs on a single 26-step divider, the divisions
// by 100 and 10000 are reciprocal multiplications, and square root adds 7
// steps. A stalled output holds the back end in its output state.
// ----------------------------------------------------------------------------
// Hall throttle conditioner top level
// Configuration registers, front end, queue, back end and divider.
// ----------------------------------------------------------------------------
module hall_throttle_conditioner #(
  parameter int WIN_LENGTH = 16,
  parameter int ADC_BITS   = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  htc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output htc_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int WIN_LOG  = htc_pkg::win_log(WIN_LENGTH);
  localparam int SAMPLE_W = (ADC_BITS < htc_pkg::SMP_W) ? ADC_BITS : htc_pkg::SMP_W;

  logic [11:0]       adc_min_r, adc_max_r;
  logic [9:0]        dz_low_r, dz_high_r, thr_min_r, thr_max_r;
  htc_pkg::curve_t   curve_r;
  logic              reverse_r;
  htc_pkg::cfg_t     cfg;
  htc_pkg::reg_idx_t idx;
  logic              wr;

  logic                      q_full, q_empty, q_push, q_pop;
  logic [htc_pkg::SMP_W-1:0] q_wdata, q_rdata;
  htc_pkg::div_req_t         div_req;
  htc_pkg::div_rsp_t         div_rsp;

  assign pready = 1'b1;
  assign idx    = htc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_min_r <= 12'd100;
      adc_max_r <= 12'd900;
      dz_low_r  <= 10'd20;
      dz_high_r <= 10'd20;
      thr_min_r <= 10'd0;
      thr_max_r <= 10'd100;
      curve_r   <= htc_pkg::CURVE_LINEAR;
      reverse_r <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        htc_pkg::REG_ADC_MIN: adc_min_r <= pwdata[11:0];
        htc_pkg::REG_ADC_MAX: adc_max_r <= pwdata[11:0];
        htc_pkg::REG_DZ_LOW:  dz_low_r  <= pwdata[9:0];
        htc_pkg::REG_DZ_HIGH: dz_high_r <= pwdata[9:0];
        htc_pkg::REG_THR_MIN: thr_min_r <= pwdata[9:0];
        htc_pkg::REG_THR_MAX: thr_max_r <= pwdata[9:0];
        htc_pkg::REG_CURVE:   curve_r   <= htc_pkg::curve_t'(pwdata[1:0]);
        htc_pkg::REG_REVERSE: reverse_r <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      htc_pkg::REG_ADC_MIN: prdata = {20'd0, adc_min_r};
      htc_pkg::REG_ADC_MAX: prdata = {20'd0, adc_max_r};
      htc_pkg::REG_DZ_LOW:  prdata = {22'd0, dz_low_r};
      htc_pkg::REG_DZ_HIGH: prdata = {22'd0, dz_high_r};
      htc_pkg::REG_THR_MIN: prdata = {22'd0, thr_min_r};
      htc_pkg::REG_THR_MAX: prdata = {22'd0, thr_max_r};
      htc_pkg::REG_CURVE:   prdata = {30'd0, curve_r};
      htc_pkg::REG_REVERSE: prdata = {31'd0, reverse_r};
    endcase
  end

  assign cfg.adc_min = adc_min_r;
  assign cfg.adc_max = adc_max_r;
  assign cfg.dz_low  = dz_low_r;
  assign cfg.dz_high = dz_high_r;
  assign cfg.thr_min = thr_min_r;
  assign cfg.thr_max = thr_max_r;
  assign cfg.curve   = curve_r;
  assign cfg.reverse = reverse_r;

  htc_front #(
    .WIN_LOG  (WIN_LOG),
    .SAMPLE_W (SAMPLE_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  htc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  htc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  htc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
